// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the checker file dtt_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/core/dtt_pkg.sv -----
package dtt_pkg;

	localparam int NUM_TIMERS = 16;
	localparam int SLOT_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int ID_CMP_W = 7;

	localparam int ID_W = 4;
	localparam int TIME_W = 48;
	localparam int PERIOD_W = 32;
	localparam int TAG_W = 16;
	localparam int KIND_W = 3;
	localparam int OP_W = 2;

	localparam int S_DATA_W = 152;
	localparam int M_DATA_W = 120;

	localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
	localparam logic [OP_W-1:0] OP_DESTROY = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK = 2'd2;

	localparam logic [KIND_W-1:0] KIND_CREATED = 3'd0;
	localparam logic [KIND_W-1:0] KIND_REJECTED = 3'd1;
	localparam logic [KIND_W-1:0] KIND_DESTROYED = 3'd2;
	localparam logic [KIND_W-1:0] KIND_UNKNOWN = 3'd3;
	localparam logic [KIND_W-1:0] KIND_FIRED = 3'd4;
	localparam logic [KIND_W-1:0] KIND_SUMMARY = 3'd5;

	typedef struct packed {
		logic [TIME_W-1:0] due;
		logic [PERIOD_W-1:0] period;
		logic periodic;
		logic [TAG_W-1:0] tag;
	} slot_entry_t;

	typedef struct packed {
		logic [KIND_W-1:0] result_kind;
		logic [ID_W-1:0] result_id;
		logic [TAG_W-1:0] fired_tag;
		logic [TIME_W-1:0] nearest_due_ms;
		logic [TIME_W-1:0] wait_ms;
		logic none_active;
		logic last;
	} result_t;

endpackage

// ----- rtl/core/deadline_timer_table_core.sv -----
// Table of dtt_pkg::NUM_TIMERS timer slots kept in one single-port-read slot memory with
// valid bits in flip-flops. An item is taken only while the block is idle. A create or
// destroy item passes through ST_ONE and gives its one result into the output register
// once that register is free. A tick item walks the slots in order, one slot per cycle
// through the memory read port unless a firing slot waits for the output register, and
// then gives its summary from ST_SUM. Each fired result comes out with last low, and the
// summary closes the tick with last high. The output register lets a finished result
// wait while the next item is taken.
module deadline_timer_table_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// timer_id, due_time_ms, period_ms, periodic, user_tag, now_ms, zero fill
	input  logic [dtt_pkg::S_DATA_W-1:0]  s_tdata,
	// operation
	input  logic [dtt_pkg::OP_W-1:0]      s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// result_id, fired_tag, nearest_due_ms, wait_ms, none_active, zero fill
	output logic [dtt_pkg::M_DATA_W-1:0]  m_tdata,
	// result_kind
	output logic [dtt_pkg::KIND_W-1:0]    m_tuser,
	output logic                          m_tlast
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ONE  = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_SUM  = 4'b1000
	} state_t;

	state_t state_q;

	logic [dtt_pkg::NUM_TIMERS-1:0] valid_q;
	dtt_pkg::slot_entry_t mem [dtt_pkg::NUM_TIMERS];
	dtt_pkg::slot_entry_t rd_data_q;

	logic [dtt_pkg::OP_W-1:0] op_q;
	logic [dtt_pkg::ID_W-1:0] id_q;
	logic [dtt_pkg::TIME_W-1:0] due_in_q;
	logic [dtt_pkg::PERIOD_W-1:0] period_in_q;
	logic periodic_in_q;
	logic [dtt_pkg::TAG_W-1:0] tag_in_q;
	logic [dtt_pkg::TIME_W-1:0] now_q;

	logic [dtt_pkg::SLOT_W-1:0] idx_q;
	logic best_vld_q;
	logic [dtt_pkg::TIME_W-1:0] best_due_q;

	dtt_pkg::result_t out_q;
	logic out_vld_q;

	logic in_acc;
	logic out_free;
	logic out_load;
	dtt_pkg::result_t out_next;

	logic rd_en;
	logic [dtt_pkg::SLOT_W-1:0] rd_addr;
	logic wr_en;
	logic [dtt_pkg::SLOT_W-1:0] wr_addr;
	dtt_pkg::slot_entry_t wr_data;

	logic [dtt_pkg::SLOT_W-1:0] free_slot;
	logic table_full;
	logic [dtt_pkg::ID_CMP_W-1:0] id_ext;
	logic id_in_range;
	logic [dtt_pkg::SLOT_W-1:0] id_slot;

	logic fire;
	logic scan_go;
	logic scan_end;
	logic [dtt_pkg::TIME_W-1:0] reload_due;
	logic [dtt_pkg::TIME_W-1:0] new_due;
	logic still_valid;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc = s_tvalid && s_tready;
	assign out_free = !out_vld_q || m_tready;

	always_comb begin
		free_slot = '0;
		for (int i = dtt_pkg::NUM_TIMERS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_slot = dtt_pkg::SLOT_W'(i);
			end
		end
	end

	assign table_full = &valid_q;
	assign id_ext = dtt_pkg::ID_CMP_W'(id_q);
	assign id_in_range = id_ext < dtt_pkg::ID_CMP_W'(dtt_pkg::NUM_TIMERS);
	assign id_slot = id_ext[dtt_pkg::SLOT_W-1:0];

	assign fire = valid_q[idx_q] && (rd_data_q.due <= now_q);
	assign scan_go = (state_q == ST_SCAN) && (!fire || out_free);
	assign scan_end = idx_q == dtt_pkg::SLOT_W'(dtt_pkg::NUM_TIMERS - 1);
	assign reload_due = rd_data_q.due + dtt_pkg::TIME_W'(rd_data_q.period);
	assign new_due = (fire && rd_data_q.periodic) ? reload_due : rd_data_q.due;
	assign still_valid = valid_q[idx_q] && !(fire && !rd_data_q.periodic);

	always_comb begin
		rd_en = 1'b0;
		rd_addr = idx_q + 1'b1;
		wr_en = 1'b0;
		wr_addr = idx_q;
		wr_data = rd_data_q;
		wr_data.due = reload_due;
		out_load = 1'b0;
		out_next = '0;
		out_next.last = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && s_tuser == dtt_pkg::OP_TICK) begin
					rd_en = 1'b1;
					rd_addr = '0;
				end
			end
			ST_ONE: begin
				if (out_free) begin
					case (op_q)
						dtt_pkg::OP_CREATE: begin
							out_load = 1'b1;
							if (table_full || due_in_q == '0) begin
								out_next.result_kind = dtt_pkg::KIND_REJECTED;
							end else begin
								out_next.result_kind = dtt_pkg::KIND_CREATED;
								out_next.result_id = dtt_pkg::ID_W'(free_slot);
								wr_en = 1'b1;
								wr_addr = free_slot;
								wr_data.due = due_in_q;
								wr_data.period = period_in_q;
								wr_data.periodic = periodic_in_q;
								wr_data.tag = tag_in_q;
							end
						end
						dtt_pkg::OP_DESTROY: begin
							out_load = 1'b1;
							out_next.result_id = id_q;
							if (id_in_range && valid_q[id_slot]) begin
								out_next.result_kind = dtt_pkg::KIND_DESTROYED;
							end else begin
								out_next.result_kind = dtt_pkg::KIND_UNKNOWN;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (scan_go) begin
					rd_en = !scan_end;
					if (fire) begin
						out_load = 1'b1;
						out_next.result_kind = dtt_pkg::KIND_FIRED;
						out_next.result_id = dtt_pkg::ID_W'(idx_q);
						out_next.fired_tag = rd_data_q.tag;
						out_next.last = 1'b0;
						wr_en = rd_data_q.periodic;
					end
				end
			end
			ST_SUM: begin
				if (out_free) begin
					out_load = 1'b1;
					out_next.result_kind = dtt_pkg::KIND_SUMMARY;
					if (best_vld_q) begin
						out_next.nearest_due_ms = best_due_q;
						if (best_due_q > now_q) begin
							out_next.wait_ms = best_due_q - now_q;
						end
					end else begin
						out_next.none_active = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			id_q <= s_tdata[3:0];
			due_in_q <= s_tdata[51:4];
			period_in_q <= s_tdata[83:52];
			periodic_in_q <= s_tdata[84];
			tag_in_q <= s_tdata[100:85];
			now_q <= s_tdata[148:101];
		end
		if (out_load) begin
			out_q <= out_next;
		end
		if (state_q == ST_IDLE) begin
			best_due_q <= '0;
		end else if (scan_go && still_valid && (!best_vld_q || new_due < best_due_q)) begin
			best_due_q <= new_due;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= dtt_pkg::OP_CREATE;
			valid_q <= '0;
			idx_q <= '0;
			best_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					best_vld_q <= 1'b0;
					if (in_acc) begin
						op_q <= s_tuser;
						if (s_tuser == dtt_pkg::OP_TICK) begin
							state_q <= ST_SCAN;
						end else if (s_tuser == dtt_pkg::OP_CREATE
								|| s_tuser == dtt_pkg::OP_DESTROY) begin
							state_q <= ST_ONE;
						end
					end
				end
				ST_ONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (op_q == dtt_pkg::OP_CREATE && !table_full && due_in_q != '0) begin
							valid_q[free_slot] <= 1'b1;
						end
						if (op_q == dtt_pkg::OP_DESTROY && id_in_range) begin
							valid_q[id_slot] <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					if (scan_go) begin
						valid_q[idx_q] <= still_valid;
						if (still_valid && (!best_vld_q || new_due < best_due_q)) begin
							best_vld_q <= 1'b1;
						end
						if (scan_end) begin
							state_q <= ST_SUM;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_SUM: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser = out_q.result_kind;
	assign m_tlast = out_q.last;
	assign m_tdata = {3'b000, out_q.none_active, out_q.wait_ms, out_q.nearest_due_ms,
		out_q.fired_tag, out_q.result_id};

endmodule

// ----- rtl/core/dtt_checker.sv -----
`include "assert_macros.svh"

module dtt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [dtt_pkg::M_DATA_W-1:0]  m_tdata,
	input logic [dtt_pkg::KIND_W-1:0]    m_tuser,
	input logic                          m_tlast
);

	// A stalled result keeps its contents until it is taken.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

	// Only a fired result leaves the item open.
	`ASSERT_SAME(a_last_kind, clk, arst_n, m_tvalid, m_tlast == (m_tuser != dtt_pkg::KIND_FIRED))

	// An empty table reports neither a due time nor a wait.
	`ASSERT_SAME(a_empty_summary, clk, arst_n, m_tvalid && m_tuser == dtt_pkg::KIND_SUMMARY && m_tdata[116], m_tdata[115:20] == '0)

	// The wait never exceeds the nearest due time.
	`ASSERT_SAME(a_wait_bound, clk, arst_n, m_tvalid && m_tuser == dtt_pkg::KIND_SUMMARY, m_tdata[115:68] <= m_tdata[67:20])

endmodule

bind deadline_timer_table_core dtt_checker u_dtt_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tuser(m_tuser),
	.m_tlast(m_tlast)
);
